// ----- hdl/twmm_pkg.sv -----
// Package for the tumbling window median/max core.
// Holds widths, reset constants, controller state codes and the command/status structs.
// No dependencies.
package twmm_pkg;

  localparam int WIN_MAX = 8;
  localparam int IDX_W   = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int FILL_W  = $clog2(WIN_MAX + 1);
  localparam int CNT_W   = 31;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(5);

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_TAKE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic insert;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic win_full;
  } dp_sts_t;

endpackage

// ----- hdl/tumbling_window_median_max_core.sv -----
// Top level of the tumbling window median/max core.
// Instantiates twmm_ctrl and twmm_dpath; depends on twmm_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, in_count, in_new_segment) takes one count per
//   transaction. Counts fill a window of cfg-selected size (0 acts as 1, above 8 as 8).
//   in_new_segment drops any partial window and starts a fresh one with this count.
//   When a window fills, one result (out_median, out_maximum) is offered on the
//   output channel (out_valid/out_stall), held in an output register.
//   Throughput: one count per cycle while in_stall is low. After the count that closes
//   a window, in_stall stays high while the result is moved from the sorted insertion
//   chain into the output register, and until that register is free to take it.
//   out_valid rises once the result has been loaded into the output register.
//   While a result waits under out_stall, counts keep being accepted until the next
//   window closes; then in_stall rises until the waiting result is taken.
//   cfg_we writes the window size and drops the partial window; write only when idle.
//   Reset (rst_n low, synchronous) sets window size 5, empties the window and
//   clears out_valid.
module tumbling_window_median_max_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [twmm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  twmm_pkg::cnt_t             in_count,
  input  logic                       in_new_segment,
  output logic                       out_valid,
  input  logic                       out_stall,
  output twmm_pkg::cnt_t             out_median,
  output twmm_pkg::cnt_t             out_maximum
);
  import twmm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  twmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  twmm_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_count       (in_count),
    .in_new_segment (in_new_segment),
    .cmd            (cmd),
    .sts            (sts),
    .out_median     (out_median),
    .out_maximum    (out_maximum)
  );

endmodule

// ----- hdl/twmm_ctrl.sv -----
// Controller for the tumbling window median/max core.
// Sequences input transactions and result loads; owns the output valid flag.
// Depends on twmm_pkg.
module twmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  twmm_pkg::dp_sts_t sts,
  output twmm_pkg::dp_cmd_t cmd
);
  import twmm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != ST_TAKE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.insert    = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state_r)
      ST_TAKE: begin
        cmd.insert = accept;
        if (accept && sts.win_full) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_TAKE;
        end
      end
      default: begin
        state_nxt = ST_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TAKE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/twmm_dpath.sv -----
// Datapath for the tumbling window median/max core.
// Window size register, fill count, sorted insertion chain, running max, result registers.
// Depends on twmm_pkg.
module twmm_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [twmm_pkg::CFG_W-1:0] cfg_wdata,
  input  twmm_pkg::cnt_t             in_count,
  input  logic                       in_new_segment,
  input  twmm_pkg::dp_cmd_t          cmd,
  output twmm_pkg::dp_sts_t          sts,
  output twmm_pkg::cnt_t             out_median,
  output twmm_pkg::cnt_t             out_maximum
);
  import twmm_pkg::*;

  logic [CFG_W-1:0]  size_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  cnt_t              sorted_r [WIN_MAX];
  cnt_t              sorted_nxt [WIN_MAX];
  cnt_t              max_r, max_nxt;
  cnt_t              med_r, peak_r;
  logic [FILL_W-1:0] eff_size;
  logic [FILL_W-1:0] fill_base;
  logic [IDX_W-1:0]  med_idx;
  logic [WIN_MAX-1:0] keep;

  always_comb begin
    if (size_r == '0) begin
      eff_size = FILL_W'(1);
    end else if (32'(size_r) > WIN_MAX) begin
      eff_size = FILL_W'(WIN_MAX);
    end else begin
      eff_size = FILL_W'(size_r);
    end
  end

  assign med_idx   = IDX_W'(eff_size >> 1);
  assign fill_base = (in_new_segment || fill_r >= eff_size) ? '0 : fill_r;
  assign sts.win_full = ((fill_base + FILL_W'(1)) >= eff_size);

  always_comb begin
    for (int i = 0; i < WIN_MAX; i++) begin
      keep[i] = (FILL_W'(i) < fill_base) && (sorted_r[i] <= in_count);
    end
    sorted_nxt[0] = keep[0] ? sorted_r[0] : in_count;
    for (int i = 1; i < WIN_MAX; i++) begin
      if (keep[i]) begin
        sorted_nxt[i] = sorted_r[i];
      end else if (keep[i-1]) begin
        sorted_nxt[i] = in_count;
      end else begin
        sorted_nxt[i] = sorted_r[i-1];
      end
    end
  end

  assign max_nxt = (fill_base == '0 || in_count > max_r) ? in_count : max_r;

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_we || cmd.emit) begin
      fill_nxt = '0;
    end else if (cmd.insert) begin
      fill_nxt = fill_base + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      sorted_r <= sorted_nxt;
      max_r    <= max_nxt;
    end
    if (cmd.emit) begin
      med_r  <= sorted_r[med_idx];
      peak_r <= max_r;
    end
  end

  assign out_median  = med_r;
  assign out_maximum = peak_r;

endmodule

// ----- hdl/twmm_props.sv -----
// Port-level assertions for the tumbling window median/max core.
// Bound to tumbling_window_median_max_core; depends on twmm_pkg.
module twmm_props (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input twmm_pkg::cnt_t out_median,
  input twmm_pkg::cnt_t out_maximum
);

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_median) && $stable(out_maximum))
    else $error("result changed while stalled");

  a_median_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_median <= out_maximum)
    else $error("median above maximum");

endmodule

bind tumbling_window_median_max_core twmm_props u_props (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_median  (out_median),
  .out_maximum (out_maximum)
);
